@@ design/pls_pkg.sv @@
// ----------------------------------------------------------------------------
// pls_pkg
// Shared widths and saturation limits for the piecewise linear segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

    // sample and slope width, signed fixed point
    localparam int VAL_W      = 25;
    // difference of two samples
    localparam int RISE_W     = VAL_W + 1;
    // intercept width, signed fixed point
    localparam int ICPT_W     = 34;
    // tolerance register width, unsigned fixed point
    localparam int TOL_W      = 24;
    // input stream data width, sample padded to whole bytes
    localparam int IN_TDATA_W = ((VAL_W + 7) / 8) * 8;

    localparam logic signed [VAL_W-1:0] SLOPE_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] SLOPE_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [ICPT_W-1:0] ICPT_MAX = {1'b0, {(ICPT_W-1){1'b1}}};
    localparam logic signed [ICPT_W-1:0] ICPT_MIN = {1'b1, {(ICPT_W-1){1'b0}}};

endpackage

`default_nettype wire

@@ design/piecewise_linear_segmenter.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_segmenter
// Splits a stream of sampled values into linear pieces; a piece closes when a
// sample leaves the trend line by more than the tolerance or turns against it.
// ----------------------------------------------------------------------------
// a sample on an active trend goes through the multiplier, deviation and
//   compare; setting up the trend line first runs the shared bit-serial
//   divider and multiplier, each closed segment runs them again, a break on
//   the final sample adds a flat piece, and emit waits out any result stall
// throughput: one item at a time, rate set by the divider and one multiplier
// reset: synchronous active low; clears the tolerance and all segment state
`default_nettype none

module piecewise_linear_segmenter
    import pls_pkg::*;
#(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // configuration write: break_tolerance
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [TOL_W-1:0]        i_cfg_data,
    // input item stream
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // [24:0] sample_value
    input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,
    // last_sample
    input  wire logic                    s_axis_tlast,
    // result item stream
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // piece_low_index, piece_high_index, piece_slope, piece_intercept
    output logic [((2*$clog2(MAX_POINTS)+VAL_W+ICPT_W+7)/8)*8-1:0] m_axis_tdata,
    // last_piece
    output logic                         m_axis_tlast
);

    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int O_DATA_W    = 2 * IDX_W + VAL_W + ICPT_W;
    localparam int O_TDATA_W   = ((O_DATA_W + 7) / 8) * 8;
    localparam int PW          = VAL_W + IDX_W + 1;
    localparam int XW          = ((PW > ICPT_W) ? PW : ICPT_W) + 2;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_POINTS - 1);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_TSTART = 14'b00000000000010,
        S_TDIV   = 14'b00000000000100,
        S_TMUL   = 14'b00000000001000,
        S_TICP   = 14'b00000000010000,
        S_DMUL   = 14'b00000000100000,
        S_DEV    = 14'b00000001000000,
        S_CMP    = 14'b00000010000000,
        S_SSTART = 14'b00000100000000,
        S_SDIV   = 14'b00001000000000,
        S_SMUL   = 14'b00010000000000,
        S_SICP   = 14'b00100000000000,
        S_EMIT   = 14'b01000000000000,
        S_FLAT   = 14'b10000000000000
    } t_state;

    t_state r_state;

    logic [TOL_W-1:0]         r_tol;
    // segment state
    logic [IDX_W-1:0]         r_point_idx;
    logic [IDX_W-1:0]         r_start_idx;
    logic signed [VAL_W-1:0]  r_start_val;
    logic signed [VAL_W-1:0]  r_prev_val;
    logic                     r_trend_act;
    logic signed [VAL_W-1:0]  r_trend_slope;
    logic signed [ICPT_W-1:0] r_trend_icpt;
    // current item
    logic signed [VAL_W-1:0]  r_v;
    logic                     r_fin;
    logic                     r_brk;
    logic [IDX_W-1:0]         r_end_idx;
    logic signed [VAL_W-1:0]  r_end_val;
    // shared multiplier
    logic signed [VAL_W-1:0]  r_mul_a;
    logic [IDX_W-1:0]         r_mul_b;
    logic signed [PW-1:0]     r_prod;
    logic signed [XW-1:0]     r_dev;
    logic signed [ICPT_W-1:0] r_seg_icpt;
    // output register
    logic                     r_out_valid;
    logic [IDX_W-1:0]         r_out_low;
    logic [IDX_W-1:0]         r_out_high;
    logic signed [VAL_W-1:0]  r_out_slope;
    logic signed [ICPT_W-1:0] r_out_icpt;
    logic                     r_out_last;

    logic                     w_accept;
    logic signed [VAL_W-1:0]  w_in_val;
    logic                     w_in_fin;
    logic                     w_out_free;
    logic                     w_emit;
    logic                     w_div_start;
    logic signed [RISE_W-1:0] w_div_rise;
    logic [IDX_W-1:0]         w_div_run;
    logic                     w_div_done;
    logic signed [VAL_W-1:0]  w_div_quot;
    logic signed [VAL_W-1:0]  w_icpt_a;
    logic signed [XW-1:0]     w_icpt_sum;
    logic signed [ICPT_W-1:0] w_icpt_sat;
    logic signed [XW-1:0]     w_dev;
    logic [XW-1:0]            w_dev_abs;
    logic signed [RISE_W-1:0] w_step;
    logic                     w_brk;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_in_val      = $signed(s_axis_tdata[VAL_W-1:0]);
    assign w_in_fin      = s_axis_tlast || (r_point_idx == LAST_IDX);
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_emit        = ((r_state == S_EMIT) || (r_state == S_FLAT)) && w_out_free;

    assign w_div_start = (r_state == S_TSTART) || (r_state == S_SSTART);
    assign w_div_rise  = RISE_W'(r_end_val) - RISE_W'(r_start_val);
    assign w_div_run   = r_end_idx - r_start_idx;

    pls_div #(
        .IDX_W (IDX_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_rise),
        .i_divisor  (w_div_run),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // intercept = value - slope * index, saturated to the intercept range
    always_comb begin
        w_icpt_a   = (r_state == S_SICP) ? r_start_val : r_v;
        w_icpt_sum = XW'(w_icpt_a) - XW'(r_prod);
        if ((&w_icpt_sum[XW-1:ICPT_W-1]) || !(|w_icpt_sum[XW-1:ICPT_W-1])) begin
            w_icpt_sat = w_icpt_sum[ICPT_W-1:0];
        end else begin
            w_icpt_sat = w_icpt_sum[XW-1] ? ICPT_MIN : ICPT_MAX;
        end
    end

    always_comb begin
        w_dev     = XW'(r_prod) + XW'(r_trend_icpt) - XW'(r_v);
        w_dev_abs = r_dev[XW-1] ? XW'(-r_dev) : XW'(r_dev);
        w_step    = RISE_W'(r_v) - RISE_W'(r_prev_val);
        w_brk     = (w_dev_abs > XW'(r_tol))
                 || (w_step[RISE_W-1] && !r_trend_slope[VAL_W-1] && (|r_trend_slope))
                 || (!w_step[RISE_W-1] && (|w_step) && r_trend_slope[VAL_W-1]);
    end

    // one multiplier, registered, shared by the deviation and by trend and segment intercepts
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(r_mul_a) * PW'($signed({1'b0, r_mul_b}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_point_idx   <= '0;
            r_start_idx   <= '0;
            r_start_val   <= '0;
            r_prev_val    <= '0;
            r_trend_act   <= 1'b0;
            r_trend_slope <= '0;
            r_trend_icpt  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_v       <= w_in_val;
                        r_fin     <= w_in_fin;
                        r_brk     <= 1'b0;
                        r_end_val <= w_in_val;
                        r_end_idx <= r_point_idx;
                        r_mul_a   <= r_trend_slope;
                        r_mul_b   <= r_point_idx;
                        if (r_point_idx == '0) begin
                            r_start_idx <= '0;
                            r_start_val <= w_in_val;
                            r_prev_val  <= w_in_val;
                            r_trend_act <= 1'b0;
                            if (w_in_fin) begin
                                r_state <= S_FLAT;
                            end else begin
                                r_point_idx <= IDX_W'(1);
                            end
                        end else if (!r_trend_act) begin
                            r_state <= S_TSTART;
                        end else begin
                            r_state <= S_DMUL;
                        end
                    end
                end
                S_TSTART: begin
                    r_state <= S_TDIV;
                end
                S_TDIV: begin
                    if (w_div_done) begin
                        r_mul_a <= w_div_quot;
                        r_mul_b <= r_point_idx;
                        r_state <= S_TMUL;
                    end
                end
                S_TMUL: begin
                    r_state <= S_TICP;
                end
                S_TICP: begin
                    // product of the new slope and index is still in r_prod
                    r_trend_slope <= r_mul_a;
                    r_trend_icpt  <= w_icpt_sat;
                    r_trend_act   <= 1'b1;
                    r_state       <= S_DEV;
                end
                S_DMUL: begin
                    r_state <= S_DEV;
                end
                S_DEV: begin
                    r_dev   <= w_dev;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_brk) begin
                        r_brk     <= 1'b1;
                        r_end_val <= r_prev_val;
                        r_end_idx <= r_point_idx - 1'b1;
                        r_state   <= S_SSTART;
                    end else if (r_fin) begin
                        r_state <= S_SSTART;
                    end else begin
                        r_prev_val  <= r_v;
                        r_point_idx <= r_point_idx + 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_SSTART: begin
                    r_state <= S_SDIV;
                end
                S_SDIV: begin
                    if (w_div_done) begin
                        r_mul_a <= w_div_quot;
                        r_mul_b <= r_start_idx;
                        r_state <= S_SMUL;
                    end
                end
                S_SMUL: begin
                    r_state <= S_SICP;
                end
                S_SICP: begin
                    r_seg_icpt <= w_icpt_sat;
                    r_state    <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_low   <= r_start_idx;
                        r_out_high  <= r_end_idx;
                        r_out_slope <= r_mul_a;
                        r_out_icpt  <= r_seg_icpt;
                        r_out_last  <= r_fin && !r_brk;
                        if (r_brk) begin
                            r_start_idx <= r_point_idx;
                            r_start_val <= r_v;
                            r_trend_act <= 1'b0;
                            if (r_fin) begin
                                r_state <= S_FLAT;
                            end else begin
                                r_prev_val  <= r_v;
                                r_point_idx <= r_point_idx + 1'b1;
                                r_state     <= S_IDLE;
                            end
                        end else begin
                            r_point_idx   <= '0;
                            r_start_idx   <= '0;
                            r_start_val   <= '0;
                            r_prev_val    <= '0;
                            r_trend_act   <= 1'b0;
                            r_trend_slope <= '0;
                            r_trend_icpt  <= '0;
                            r_state       <= S_IDLE;
                        end
                    end
                end
                S_FLAT: begin
                    // single-point piece closing the domain
                    if (w_out_free) begin
                        r_out_low     <= r_point_idx;
                        r_out_high    <= r_point_idx;
                        r_out_slope   <= '0;
                        r_out_icpt    <= ICPT_W'(r_v);
                        r_out_last    <= 1'b1;
                        r_point_idx   <= '0;
                        r_start_idx   <= '0;
                        r_start_val   <= '0;
                        r_prev_val    <= '0;
                        r_trend_act   <= 1'b0;
                        r_trend_slope <= '0;
                        r_trend_icpt  <= '0;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{(O_TDATA_W-O_DATA_W){1'b0}},
                            r_out_icpt, r_out_slope, r_out_high, r_out_low};

endmodule

`default_nettype wire

@@ design/pls_div.sv @@
// ----------------------------------------------------------------------------
// pls_div
// Shared restoring divider: signed rise over unsigned run, one quotient bit
// per cycle, truncated toward zero and saturated to the slope range.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_div
    import pls_pkg::*;
#(
    parameter int IDX_W = 10
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [RISE_W-1:0] i_dividend,
    input  wire logic [IDX_W-1:0]         i_divisor,
    output logic                          o_done,
    output logic signed [VAL_W-1:0]       o_quot
);

    localparam int CNT_W = $clog2(RISE_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(RISE_W - 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [IDX_W-1:0]    r_rem;
    logic [RISE_W-1:0]   r_q;
    logic [IDX_W-1:0]    r_dvs;
    logic                r_neg;
    logic                r_zero;

    logic [RISE_W-1:0]   w_mag;
    logic [IDX_W:0]      w_rem_sh;
    logic [IDX_W+1:0]    w_diff;
    logic                w_ge;
    logic                w_pos_ovf;
    logic                w_neg_ovf;
    logic [VAL_W-1:0]    w_qlo;

    always_comb begin
        w_mag     = i_dividend[RISE_W-1] ? RISE_W'(-i_dividend) : RISE_W'(i_dividend);
        w_rem_sh  = {r_rem, r_q[RISE_W-1]};
        w_diff    = {1'b0, w_rem_sh} - {2'b00, r_dvs};
        w_ge      = !w_diff[IDX_W+1];
        w_qlo     = r_q[VAL_W-1:0];
        w_pos_ovf = r_q[RISE_W-1] | r_q[VAL_W-1];
        w_neg_ovf = r_q[RISE_W-1] | (r_q[VAL_W-1] & (|r_q[VAL_W-2:0]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // the dividend magnitude shifts out of r_q as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= w_mag;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
            r_neg  <= i_dividend[RISE_W-1];
            r_zero <= (i_divisor == '0);
        end else if (r_busy) begin
            r_q <= {r_q[RISE_W-2:0], w_ge};
            if (w_ge) begin
                r_rem <= w_diff[IDX_W-1:0];
            end else begin
                r_rem <= w_rem_sh[IDX_W-1:0];
            end
        end
    end

    always_comb begin
        if (r_zero) begin
            o_quot = '0;
        end else if (r_neg) begin
            o_quot = w_neg_ovf ? SLOPE_MIN : $signed(-w_qlo);
        end else begin
            o_quot = w_pos_ovf ? SLOPE_MAX : $signed(w_qlo);
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

@@ verif/pls_checker.sv @@
// ----------------------------------------------------------------------------
// pls_checker
// Watches the tolerance write channel and both item streams of the segmenter,
// keeps its own copy of the segment state, works out the pieces each sample
// must produce and compares every piece that leaves the block, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_checker
    import pls_pkg::*;
#(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_valid,
    input  wire logic                    i_cfg_ready,
    input  wire logic [TOL_W-1:0]        i_cfg_data,
    input  wire logic                    i_s_tvalid,
    input  wire logic                    i_s_tready,
    // [24:0] sample_value
    input  wire logic [IN_TDATA_W-1:0]   i_s_tdata,
    // last_sample
    input  wire logic                    i_s_tlast,
    input  wire logic                    i_m_tvalid,
    input  wire logic                    i_m_tready,
    // piece_low_index, piece_high_index, piece_slope, piece_intercept
    input  wire logic [((2*$clog2(MAX_POINTS)+VAL_W+ICPT_W+7)/8)*8-1:0] i_m_tdata,
    // last_piece
    input  wire logic                    i_m_tlast,
    output int                           o_errors,
    output int                           o_pieces,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W      = $clog2(MAX_POINTS);

    typedef struct packed {
        logic [IDX_W-1:0]         lo_idx;
        logic [IDX_W-1:0]         hi_idx;
        logic signed [VAL_W-1:0]  slope;
        logic signed [ICPT_W-1:0] icpt;
        logic                     fin;
    } t_piece;

    t_piece                   pieces_due[$];
    logic [TOL_W-1:0]         tolerance;
    logic [IDX_W-1:0]         at_index;
    logic [IDX_W-1:0]         seg_lo;
    logic signed [VAL_W-1:0]  seg_first;
    logic signed [VAL_W-1:0]  last_val;
    logic signed [VAL_W-1:0]  trend_slope;
    logic signed [ICPT_W-1:0] trend_icpt;
    logic                     trend_set;

    initial begin
        o_errors  = 0;
        o_pieces  = 0;
        o_pending = 0;
    end

    function automatic longint clip(longint x, longint lo, longint hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    // truncating division, saturated to the slope width; no run means flat
    function automatic longint rise_over_run(longint rise, longint run);
        if (run <= 0) return 0;
        return clip(rise / run, longint'(SLOPE_MIN), longint'(SLOPE_MAX));
    endfunction

    function automatic longint icpt_at(longint v, longint slope, longint idx);
        return clip(v - slope * idx, longint'(ICPT_MIN), longint'(ICPT_MAX));
    endfunction

    function automatic void queue_piece(longint lo, longint hi, longint slope,
                                        longint icpt, logic fin);
        t_piece p;
        p.lo_idx = lo[IDX_W-1:0];
        p.hi_idx = hi[IDX_W-1:0];
        p.slope  = slope[VAL_W-1:0];
        p.icpt   = icpt[ICPT_W-1:0];
        p.fin    = fin;
        pieces_due.insert(pieces_due.size(), p);
    endfunction

    function automatic void close_segment(longint hi, longint end_val, logic fin);
        longint s;
        s = rise_over_run(end_val - longint'(seg_first), hi - longint'(seg_lo));
        queue_piece(longint'(seg_lo), hi, s,
                    icpt_at(longint'(seg_first), s, longint'(seg_lo)), fin);
    endfunction

    function automatic void restart_domain();
        at_index    = '0;
        seg_lo      = '0;
        seg_first   = '0;
        last_val    = '0;
        trend_set   = 1'b0;
        trend_slope = '0;
        trend_icpt  = '0;
    endfunction

    function automatic void segment_sample(logic signed [VAL_W-1:0] v, logic last_in);
        longint idx;
        longint dev;
        longint stp;
        logic   fin;
        logic   brk;
        idx = longint'(at_index);
        // the index saturates at the top of the domain and forces the end
        fin = last_in || (idx >= MAX_POINTS - 1);
        if (idx == 0) begin
            seg_lo    = '0;
            seg_first = v;
            last_val  = v;
            trend_set = 1'b0;
            if (fin) begin
                queue_piece(0, 0, 0, longint'(v), 1'b1);
                restart_domain();
            end else begin
                at_index = 1;
            end
        end else begin
            if (!trend_set) begin
                trend_slope = rise_over_run(longint'(v) - longint'(seg_first),
                                            idx - longint'(seg_lo));
                trend_icpt  = icpt_at(longint'(v), longint'(trend_slope), idx);
                trend_set   = 1'b1;
            end
            dev = longint'(trend_slope) * idx + longint'(trend_icpt) - longint'(v);
            if (dev < 0) dev = -dev;
            stp = longint'(v) - longint'(last_val);
            brk = (dev > longint'(tolerance)) ||
                  (stp < 0 && trend_slope > 0) || (stp > 0 && trend_slope < 0);
            if (brk) begin
                close_segment(idx - 1, longint'(last_val), 1'b0);
                // a break on the final sample leaves a one-point flat piece
                if (fin) queue_piece(idx, idx, 0, longint'(v), 1'b1);
                seg_lo    = idx[IDX_W-1:0];
                seg_first = v;
                trend_set = 1'b0;
            end else if (fin) begin
                close_segment(idx, longint'(v), 1'b1);
            end
            last_val = v;
            if (fin) restart_domain();
            else at_index = idx[IDX_W-1:0] + 1'b1;
        end
    endfunction

    task automatic report(string what, longint got, longint want);
        o_errors++;
        $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    task automatic check_piece(logic [$bits(i_m_tdata)-1:0] data, logic last_in);
        t_piece got;
        t_piece want;
        got.lo_idx = data[IDX_W-1:0];
        got.hi_idx = data[2*IDX_W-1:IDX_W];
        got.slope  = data[2*IDX_W +: VAL_W];
        got.icpt   = data[2*IDX_W+VAL_W +: ICPT_W];
        got.fin    = last_in;
        if (pieces_due.size() == 0) begin
            report("piece with nothing due, low index", longint'(got.lo_idx), -1);
        end else begin
            want = pieces_due.pop_front();
            o_pieces++;
            if (got.lo_idx !== want.lo_idx)
                report("low index", longint'(got.lo_idx), longint'(want.lo_idx));
            if (got.hi_idx !== want.hi_idx)
                report("high index", longint'(got.hi_idx), longint'(want.hi_idx));
            if (got.slope !== want.slope)
                report("slope", longint'(got.slope), longint'(want.slope));
            if (got.icpt !== want.icpt)
                report("intercept", longint'(got.icpt), longint'(want.icpt));
            if (got.fin !== want.fin)
                report("last piece", longint'(got.fin), longint'(want.fin));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tolerance = '0;
            restart_domain();
            pieces_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) tolerance = i_cfg_data;
            if (i_s_tvalid && i_s_tready) segment_sample(i_s_tdata[VAL_W-1:0], i_s_tlast);
            if (i_m_tvalid && i_m_tready) check_piece(i_m_tdata, i_m_tlast);
        end
        o_pending = pieces_due.size();
    end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the piecewise linear segmenter with directed sample runs, one domain
// that runs into index saturation under a long output stall, and random
// domains under changing break tolerances; a checker compares every piece.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pls_pkg::*;

    localparam int     MAX_POINTS  = 1024;
    localparam int     IDX_W       = $clog2(MAX_POINTS);
    localparam int     OUT_W       = ((2*IDX_W+VAL_W+ICPT_W+7)/8)*8;
    localparam int     CLK_HALF    = 4;
    localparam int     LIMIT       = 1000000;
    localparam int     DRAIN       = 100;
    localparam int     STALL_LEN   = 2500;
    localparam int     ITEM_TARGET = 1600;
    localparam longint VAL_HI      = (longint'(1) <<< (VAL_W-1)) - 1;
    localparam longint VAL_LO      = -(longint'(1) <<< (VAL_W-1));
    localparam logic [TOL_W-1:0] TOL_MAX  = '1;
    localparam logic [TOL_W-1:0] TOL_UNIT = TOL_W'(1 << 16);

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [TOL_W-1:0]      i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  m_axis_tlast;

    int               fail_count;
    int               pieces_seen;
    int               pieces_owed;
    int               sent;
    int               domains;
    int               tol_settings;
    int               cycle_count;
    logic [TOL_W-1:0] tol_now;
    bit               gaps_on;
    bit               hold_results;

    piecewise_linear_segmenter #(
        .MAX_POINTS(MAX_POINTS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    pls_checker #(
        .MAX_POINTS(MAX_POINTS)
    ) u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tlast   (s_axis_tlast),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tlast   (m_axis_tlast),
        .o_errors    (fail_count),
        .o_pieces    (pieces_seen),
        .o_pending   (pieces_owed)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d pieces still due", cycle_count, pieces_owed);
        $display("Some tests failed");
        $finish;
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        int hold;
        int wait_n;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_results) begin
                m_axis_tready <= 1'b0;
                hold = 0;
                while (hold < STALL_LEN) begin
                    @(negedge i_clk);
                    hold++;
                end
                hold_results = 1'b0;
            end
            wait_n = gaps_on ? $urandom_range(0, 18) : 0;
            if (wait_n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    function automatic longint clip_sample(longint x);
        if (x < VAL_LO) return VAL_LO;
        if (x > VAL_HI) return VAL_HI;
        return x;
    endfunction

    function automatic longint any_sample();
        logic signed [VAL_W-1:0] r;
        r = VAL_W'($urandom);
        return longint'(r);
    endfunction

    function automatic longint pick_slope();
        longint m;
        case ($urandom_range(0, 3))
            0: m = 0;
            1: m = $urandom_range(0, 255);
            2: m = $urandom_range(0, 65535);
            default: m = $urandom_range(0, 1 << 20);
        endcase
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    function automatic longint jitter(longint amp);
        if (amp <= 0) return 0;
        return longint'($urandom_range(0, 32'(amp))) - amp / 2;
    endfunction

    // entered and left at a falling edge
    task automatic send_sample(longint v, bit last);
        int gap;
        logic [VAL_W-1:0] bits;
        gap  = gaps_on ? $urandom_range(0, 18) : 0;
        bits = v[VAL_W-1:0];
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-VAL_W){1'b0}}, bits};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic send_run(longint run_q[$]);
        foreach (run_q[k]) send_sample(run_q[k], k == run_q.size() - 1);
        domains++;
    endtask

    // wait for every piece due, then for a sample still in flight
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pieces_owed != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    task automatic write_tolerance(logic [TOL_W-1:0] t);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= t;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        tol_now = t;
        tol_settings++;
    endtask

    // runs to the index limit without a last flag; extreme jumps on the way
    task automatic saturating_domain();
        longint base;
        longint slope;
        longint v;
        int     k;
        base  = 0;
        slope = pick_slope();
        for (k = 0; k < MAX_POINTS; k++) begin
            if (k % 37 == 0) slope = pick_slope();
            base = clip_sample(base + slope + jitter(((k / 128) % 2) ? 4096 : 0));
            case (k % 61)
                58, 60:  v = VAL_LO;
                59:      v = VAL_HI;
                default: v = base;
            endcase
            send_sample(v, 1'b0);
        end
        domains++;
    endtask

    task automatic random_domain();
        longint run_q[$];
        longint base;
        longint slope;
        longint amp;
        int     kind;
        int     len;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // noise over the full sample range
            len = $urandom_range(1, 12);
            repeat (len) run_q.insert(run_q.size(), any_sample());
        end else if (kind == 1) begin
            run_q.insert(run_q.size(), any_sample());
        end else begin
            base = jitter(longint'(1) << 23);
            repeat ($urandom_range(1, 4)) begin
                slope = pick_slope();
                case ($urandom_range(0, 3))
                    0, 1:    amp = 0;
                    2:       amp = longint'(tol_now) / 2;
                    default: amp = longint'(tol_now) * 2 + 256;
                endcase
                len = $urandom_range(2, 10);
                repeat (len) begin
                    base = clip_sample(base + slope);
                    run_q.insert(run_q.size(), clip_sample(base + jitter(amp)));
                end
            end
        end
        send_run(run_q);
    endtask

    initial begin
        longint run_q[$];
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        sent          = 0;
        domains       = 0;
        tol_settings  = 0;
        tol_now       = '0;
        gaps_on       = 1'b1;
        hold_results  = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed runs under zero tolerance
        write_tolerance('0);
        run_q = '{VAL_HI};
        send_run(run_q);
        run_q = '{VAL_LO};
        send_run(run_q);
        run_q = '{1000, 1003, 1006, 1009, 1012};
        send_run(run_q);
        // deviation break, turn against the trend, then a break on the last sample
        run_q = '{0, 10, 20, 35, 45, 40, 38, 100};
        send_run(run_q);
        // slope saturates, then a break on the last sample
        run_q = '{VAL_LO, VAL_HI, VAL_LO};
        send_run(run_q);
        run_q = '{-5, -5, -5};
        send_run(run_q);

        // full-length domain with the result side held off for a while
        write_tolerance(TOL_MAX);
        gaps_on      = 1'b0;
        hold_results = 1'b1;
        saturating_domain();

        while (sent < ITEM_TARGET) begin
            if (domains % 6 == 0) begin
                case ($urandom_range(0, 4))
                    0:       write_tolerance('0);
                    1:       write_tolerance(TOL_MAX);
                    2:       write_tolerance(TOL_UNIT);
                    3:       write_tolerance(TOL_W'($urandom_range(0, 1 << 20)));
                    default: write_tolerance(TOL_W'($urandom));
                endcase
            end
            gaps_on = ($urandom_range(0, 3) != 0);
            random_domain();
        end

        settle();
        $display("covered %0d samples in %0d domains, one run to index saturation",
                 sent, domains);
        $display("%0d pieces checked over %0d tolerance writes, with a %0d-cycle result stall",
                 pieces_seen, tol_settings, STALL_LEN);
        if (fail_count == 0 && pieces_owed == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
design/pls_pkg.sv
design/pls_div.sv
design/piecewise_linear_segmenter.sv
verif/pls_checker.sv
verif/testbench.sv
